// ===== rtl/core/rpsr_pkg.sv =====
// Shared types and constants of the ramped PI speed regulator.
// Used by the channel interfaces, the serial PI multiplier, the top level and the checker.
`timescale 1ns / 1ps
package rpsr_pkg;

  // Default sensor geometry and tick rate.
  localparam int EDGES_PER_REV    = 26;
  localparam int TICKS_PER_SECOND = 100;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int TARGET_W   = 16;
  localparam int DUTY_W     = 7;
  localparam int ACTION_W   = 2;
  localparam int SPEED_W    = 24;
  localparam int REF_W      = 32;
  localparam int GAIN_W     = 48;
  localparam int ACC_W      = 48;
  localparam int ERR_W      = 33;
  localparam int DELTA_W    = 11;
  localparam int STEP_W     = 16;
  localparam int BAND_W     = 14;
  localparam int RELEASE_W  = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_HALL  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

  // Drive action codes of a result word.
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DUTY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HALT = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_START = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESTOP_STEP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 4'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0]    KP_RST         = 48'd5497558139;
  localparam logic [GAIN_W-1:0]    KI_RST         = 48'd5498;
  localparam logic [DUTY_W-1:0]    DUTY_START_RST = 7'd25;
  localparam logic [DUTY_W-1:0]    DUTY_MAX_RST   = 7'd95;
  localparam logic [STEP_W-1:0]    RAMP_STEP_RST  = 16'd1280;
  localparam logic [STEP_W-1:0]    ESTOP_STEP_RST = 16'd2560;
  localparam logic [BAND_W-1:0]    BAND_RST       = 14'd500;
  localparam logic [RELEASE_W-1:0] RELEASE_RST    = 16'd1000;

  // Control law constants.
  localparam int ACCEL_MARGIN_RPM = 100;
  localparam int STOP_RELEASE_RPM = 500;
  localparam int DELTA_LIMIT      = 1000;

  // Status of the serial multiplier toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } rpsr_mul_stat_t;

endpackage

// ===== rtl/core/rpsr_if.sv =====
// Valid/ready channel interfaces of the speed regulator: input, result and register write.
// Depends on rpsr_pkg for field widths.
`timescale 1ns / 1ps
interface rpsr_in_if;
  logic                             valid;
  logic                             ready;
  logic [rpsr_pkg::OP_W-1:0]        operation;
  logic [rpsr_pkg::TARGET_W-1:0]    target_rpm;
  logic                             estop_request;
  modport source(output valid, operation, target_rpm, estop_request, input ready);
  modport sink(input valid, operation, target_rpm, estop_request, output ready);
endinterface

interface rpsr_out_if;
  logic                             valid;
  logic                             ready;
  logic [rpsr_pkg::DUTY_W-1:0]      duty_percent;
  logic [rpsr_pkg::ACTION_W-1:0]    drive_action;
  logic                             restart_pulse;
  logic [rpsr_pkg::SPEED_W-1:0]     measured_rpm_q8;
  logic signed [rpsr_pkg::REF_W-1:0] reference_rpm_q8;
  logic                             estop_active;
  logic                             stop_active;
  modport source(output valid, duty_percent, drive_action, restart_pulse, measured_rpm_q8,
                 reference_rpm_q8, estop_active, stop_active, input ready);
  modport sink(input valid, duty_percent, drive_action, restart_pulse, measured_rpm_q8,
               reference_rpm_q8, estop_active, stop_active, output ready);
endinterface

interface rpsr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpsr_pkg::CFG_IDX_W-1:0]   index;
  logic [rpsr_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/rpsr_pi_mul.sv =====
// Bit-serial PI product: trunc((kp*err + ki*acc) / 2^48), limited to +-1000.
// One gain bit per cycle for both gains at once; depends on rpsr_pkg.
`timescale 1ns / 1ps
module rpsr_pi_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [rpsr_pkg::ERR_W-1:0]     err,
  input  logic signed [rpsr_pkg::ACC_W-1:0]     acc,
  input  logic [rpsr_pkg::GAIN_W-1:0]           kp,
  input  logic [rpsr_pkg::GAIN_W-1:0]           ki,
  output rpsr_pkg::rpsr_mul_stat_t              stat,
  output logic signed [rpsr_pkg::DELTA_W-1:0]   delta
);
  localparam int GW    = rpsr_pkg::GAIN_W;
  localparam int HI_W  = 51;
  localparam int CNT_W = $clog2(GW);

  logic                    busy_r, busy_nxt;
  logic                    fin_r, fin_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [GW-1:0]           kp_sh_r, kp_sh_nxt, ki_sh_r, ki_sh_nxt;
  logic signed [rpsr_pkg::ERR_W-1:0] err_r, err_nxt;
  logic signed [rpsr_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [HI_W-1:0]  hi_r, hi_nxt;
  logic [GW-1:0]           lo_r, lo_nxt;
  logic signed [rpsr_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [HI_W-1:0]  term, sum, quo;

  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    kp_sh_nxt = kp_sh_r;
    ki_sh_nxt = ki_sh_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    delta_nxt = delta_r;
    // add the selected multiplicands at the current gain bit
    term = (kp_sh_r[0] ? {{(HI_W-rpsr_pkg::ERR_W){err_r[rpsr_pkg::ERR_W-1]}}, err_r}
                       : '0)
         + (ki_sh_r[0] ? {{(HI_W-rpsr_pkg::ACC_W){acc_r[rpsr_pkg::ACC_W-1]}}, acc_r}
                       : '0);
    sum  = hi_r + term;
    // round the high part toward zero
    quo  = hi_r + ((hi_r[HI_W-1] && (lo_r != '0)) ? HI_W'(1) : HI_W'(0));
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      kp_sh_nxt = kp;
      ki_sh_nxt = ki;
      err_nxt   = err;
      acc_nxt   = acc;
      hi_nxt    = '0;
      lo_nxt    = '0;
    end else if (busy_r) begin
      // shift one product bit out per cycle
      hi_nxt    = sum >>> 1;
      lo_nxt    = {sum[0], lo_r[GW-1:1]};
      kp_sh_nxt = kp_sh_r >> 1;
      ki_sh_nxt = ki_sh_r >> 1;
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(GW - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      // limit the step and report
      if (quo > HI_W'(rpsr_pkg::DELTA_LIMIT)) begin
        delta_nxt = rpsr_pkg::DELTA_W'(rpsr_pkg::DELTA_LIMIT);
      end else if (quo < -HI_W'(rpsr_pkg::DELTA_LIMIT)) begin
        delta_nxt = -rpsr_pkg::DELTA_W'(rpsr_pkg::DELTA_LIMIT);
      end else begin
        delta_nxt = quo[rpsr_pkg::DELTA_W-1:0];
      end
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    kp_sh_r <= kp_sh_nxt;
    ki_sh_r <= ki_sh_nxt;
    err_r   <= err_nxt;
    acc_r   <= acc_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    delta_r <= delta_nxt;
  end

  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;
  assign delta     = delta_r;
endmodule

// ===== rtl/core/ramped_pi_motor_speed_regulator.sv =====
// Ramped PI motor speed regulator: top level with sequencer, serial divider and state.
// Depends on rpsr_pkg, the rpsr channel interfaces and rpsr_pi_mul.
//
// Usage:
//  in_item carries one word per hall edge, period tick, start or stop command.
//  out_item returns exactly one result word per input word, in order.
//  cfg_wr writes one register (index, data); it is always ready, and the user must
//  write it only while the block is idle; the block does not enforce this. Indexes
//  beyond the register list and the duty start index are dropped.
// Timing:
//  Hall, start and stop words load the result register directly, which is valid on
//  the next cycle. A tick runs a bit-serial division of the edge count by the edges
//  per revolution, one control step, and for a PI step the bit-serial 48-bit gain
//  product with its handoff via the multiplier start register and the finish state;
//  a halting tick skips the product. One word is in flight at a time; the next word is
//  taken when the block is idle and the result register is empty or being drained.
// Reset:
//  Registers take their default values, duty returns to the default start duty,
//  stop is set, estop, reference, error sum and edge count clear.
// Stall:
//  A stalled result is held in the output register; a finishing tick waits
//  until that register is free.
`timescale 1ns / 1ps
module ramped_pi_motor_speed_regulator #(
  parameter int EDGES_PER_REV    = rpsr_pkg::EDGES_PER_REV,
  parameter int TICKS_PER_SECOND = rpsr_pkg::TICKS_PER_SECOND
) (
  input  logic        clk,
  input  logic        rst_n,
  rpsr_in_if.sink     in_item,
  rpsr_out_if.source  out_item,
  rpsr_cfg_if.sink    cfg_wr
);
  localparam longint SPEED_K = longint'(60) * longint'(TICKS_PER_SECOND) * longint'(256);
  localparam longint HALF    = longint'(EDGES_PER_REV / 2);
  localparam longint NUM_MAX = longint'(255) * SPEED_K + HALF;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DIV_W   = $clog2(EDGES_PER_REV + 1);
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int WIDE_W  = ((NUM_W > rpsr_pkg::SPEED_W) ? NUM_W : rpsr_pkg::SPEED_W) + 1;
  localparam int SW      = 34;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration registers
  logic [rpsr_pkg::GAIN_W-1:0]    kp_r, kp_nxt, ki_r, ki_nxt;
  logic [rpsr_pkg::DUTY_W-1:0]    duty_max_r, duty_max_nxt;
  logic [rpsr_pkg::STEP_W-1:0]    rstep_r, rstep_nxt, estep_r, estep_nxt;
  logic [rpsr_pkg::BAND_W-1:0]    band_r, band_nxt;
  logic [rpsr_pkg::RELEASE_W-1:0] release_r, release_nxt;

  // regulator state
  logic [7:0]                          edge_r, edge_nxt;
  logic signed [rpsr_pkg::REF_W-1:0]   ref_r, ref_nxt;
  logic signed [rpsr_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [rpsr_pkg::DUTY_W-1:0]         duty_r, duty_nxt;
  logic                                estop_r, estop_nxt, stop_r, stop_nxt;

  // sequencer and working registers
  logic [2:0]                          state_r, state_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic [NUM_W-1:0]                    num_r, num_nxt;
  logic [DIV_W-1:0]                    rem_r, rem_nxt;
  logic [rpsr_pkg::TARGET_W-1:0]       target_r, target_nxt;
  logic                                req_r, req_nxt;
  logic [rpsr_pkg::SPEED_W-1:0]        speed_r, speed_nxt;
  logic                                restart_r, restart_nxt;
  logic signed [rpsr_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic                                mul_start_r, mul_start_nxt;

  // result register
  logic                                ov_r, ov_nxt;
  logic [rpsr_pkg::DUTY_W-1:0]         o_duty_r, o_duty_nxt;
  logic [rpsr_pkg::ACTION_W-1:0]       o_act_r, o_act_nxt;
  logic                                o_restart_r, o_restart_nxt;
  logic [rpsr_pkg::SPEED_W-1:0]        o_speed_r, o_speed_nxt;
  logic signed [rpsr_pkg::REF_W-1:0]   o_ref_r, o_ref_nxt;
  logic                                o_estop_r, o_estop_nxt, o_stop_r, o_stop_nxt;

  // combinational helpers
  logic                                in_fire, out_fire, out_free, load;
  logic [rpsr_pkg::ACTION_W-1:0]       load_act;
  logic                                load_restart;
  logic [rpsr_pkg::SPEED_W-1:0]        load_speed;
  logic [DIV_W:0]                      rem2;
  logic                                ge;
  logic [WIDE_W-1:0]                   num_ext;
  logic [rpsr_pkg::SPEED_W-1:0]        speed_c;
  logic signed [SW-1:0]                spd_s, tgt_s, hi_lim, lo_lim, acc_lim, ramp_v, err_w;
  logic signed [rpsr_pkg::REF_W-1:0]   ref_new;
  logic                                estop1;
  logic signed [rpsr_pkg::ACC_W:0]     asum;
  logic signed [11:0]                  dsum;
  rpsr_pkg::rpsr_mul_stat_t            mul_stat;
  logic signed [rpsr_pkg::DELTA_W-1:0] mul_delta;

  assign in_fire  = in_item.valid & in_item.ready;
  assign out_fire = out_item.valid & out_item.ready;
  assign out_free = !ov_r || out_item.ready;

  assign in_item.ready = (state_r == ST_IDLE) && out_free;
  assign cfg_wr.ready  = 1'b1;

  rpsr_pi_mul u_pi_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .err   (err_r),
    .acc   (acc_r),
    .kp    (kp_r),
    .ki    (ki_r),
    .stat  (mul_stat),
    .delta (mul_delta)
  );

  always_comb begin
    kp_nxt = kp_r; ki_nxt = ki_r; duty_max_nxt = duty_max_r;
    rstep_nxt = rstep_r; estep_nxt = estep_r; band_nxt = band_r; release_nxt = release_r;
    edge_nxt = edge_r; ref_nxt = ref_r; acc_nxt = acc_r; duty_nxt = duty_r;
    estop_nxt = estop_r; stop_nxt = stop_r;
    state_nxt = state_r; cnt_nxt = cnt_r; num_nxt = num_r; rem_nxt = rem_r;
    target_nxt = target_r; req_nxt = req_r; speed_nxt = speed_r;
    restart_nxt = restart_r; err_nxt = err_r; mul_start_nxt = 1'b0;
    load = 1'b0; load_act = rpsr_pkg::ACT_NONE; load_restart = 1'b0; load_speed = '0;

    // register writes
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        rpsr_pkg::REG_KP:         kp_nxt = cfg_wr.data;
        rpsr_pkg::REG_KI:         ki_nxt = cfg_wr.data;
        rpsr_pkg::REG_DUTY_MAX:   duty_max_nxt = cfg_wr.data[rpsr_pkg::DUTY_W-1:0];
        rpsr_pkg::REG_RAMP_STEP:  rstep_nxt = cfg_wr.data[rpsr_pkg::STEP_W-1:0];
        rpsr_pkg::REG_ESTOP_STEP: estep_nxt = cfg_wr.data[rpsr_pkg::STEP_W-1:0];
        rpsr_pkg::REG_BAND:       band_nxt = cfg_wr.data[rpsr_pkg::BAND_W-1:0];
        rpsr_pkg::REG_RELEASE:    release_nxt = cfg_wr.data[rpsr_pkg::RELEASE_W-1:0];
        default: ;
      endcase
    end

    // one restoring division step
    rem2 = {rem_r, num_r[NUM_W-1]};
    ge   = rem2 >= (DIV_W+1)'(EDGES_PER_REV);

    // speed limit and tick decision terms
    num_ext = WIDE_W'(num_r);
    speed_c = (num_ext > WIDE_W'({rpsr_pkg::SPEED_W{1'b1}})) ? {rpsr_pkg::SPEED_W{1'b1}}
                                                              : num_r[rpsr_pkg::SPEED_W-1:0];
    spd_s   = SW'(speed_c);
    tgt_s   = SW'(target_r);
    hi_lim  = (tgt_s + SW'(band_r)) <<< 8;
    lo_lim  = (tgt_s - SW'(band_r)) <<< 8;
    acc_lim = (tgt_s - SW'(rpsr_pkg::ACCEL_MARGIN_RPM)) <<< 8;
    if (estop_r && speed_c != '0) begin
      ramp_v = SW'(ref_r) - SW'(estep_r);
    end else if (stop_r && speed_c != '0) begin
      ramp_v = SW'(ref_r) - SW'(rstep_r);
    end else if (spd_s < acc_lim) begin
      ramp_v = SW'(ref_r) + SW'(rstep_r);
    end else begin
      ramp_v = SW'(ref_r) - SW'(rstep_r);
    end
    if (estop_r || stop_r || spd_s > hi_lim || spd_s < lo_lim) begin
      if (ramp_v[SW-1:rpsr_pkg::REF_W-1] == '0 ||
          ramp_v[SW-1:rpsr_pkg::REF_W-1] == '1) begin
        ref_new = ramp_v[rpsr_pkg::REF_W-1:0];
      end else begin
        ref_new = ramp_v[SW-1] ? {1'b1, {(rpsr_pkg::REF_W-1){1'b0}}}
                               : {1'b0, {(rpsr_pkg::REF_W-1){1'b1}}};
      end
    end else begin
      ref_new = rpsr_pkg::REF_W'(tgt_s <<< 8);
    end
    estop1 = estop_r | req_r;
    err_w  = SW'(ref_new) - spd_s;
    asum   = (rpsr_pkg::ACC_W+1)'(acc_r) + (rpsr_pkg::ACC_W+1)'(err_w);
    dsum   = 12'(duty_r) + 12'(mul_delta);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item.operation)
            rpsr_pkg::OP_HALL: begin
              if (edge_r != 8'hFF) edge_nxt = edge_r + 8'd1;
              load = 1'b1;
            end
            rpsr_pkg::OP_START: begin
              edge_nxt = '0;
              stop_nxt = 1'b0;
              load     = 1'b1;
            end
            rpsr_pkg::OP_STOP: begin
              stop_nxt = 1'b1;
              load     = 1'b1;
            end
            default: begin
              // tick: start the speed division
              num_nxt    = NUM_W'(longint'(edge_r) * SPEED_K + HALF);
              rem_nxt    = '0;
              cnt_nxt    = '0;
              edge_nxt   = '0;
              target_nxt = in_item.target_rpm;
              req_nxt    = in_item.estop_request;
              state_nxt  = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? DIV_W'(rem2 - (DIV_W+1)'(EDGES_PER_REV)) : rem2[DIV_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        restart_nxt = (speed_c == '0) && !estop_r && !stop_r;
        speed_nxt   = speed_c;
        if (estop1 && spd_s <= (SW'(release_r) <<< 8)) begin
          // hold until the result register is free, then halt
          if (out_free) begin
            estop_nxt = 1'b0;
            stop_nxt  = 1'b1;
            ref_nxt   = '0;
            load      = 1'b1;
            load_act  = rpsr_pkg::ACT_HALT;
            load_restart = restart_nxt;
            load_speed   = speed_c;
            state_nxt = ST_IDLE;
          end
        end else if (stop_r && spd_s <= SW'(rpsr_pkg::STOP_RELEASE_RPM * 256)) begin
          if (out_free) begin
            estop_nxt = estop1;
            ref_nxt   = '0;
            load      = 1'b1;
            load_act  = rpsr_pkg::ACT_HALT;
            load_restart = restart_nxt;
            load_speed   = speed_c;
            state_nxt = ST_IDLE;
          end
        end else begin
          // PI step: update error sum, start the product
          estop_nxt = estop1;
          ref_nxt   = ref_new;
          err_nxt   = err_w[rpsr_pkg::ERR_W-1:0];
          if (asum[rpsr_pkg::ACC_W] != asum[rpsr_pkg::ACC_W-1]) begin
            acc_nxt = asum[rpsr_pkg::ACC_W] ? {1'b1, {(rpsr_pkg::ACC_W-1){1'b0}}}
                                            : {1'b0, {(rpsr_pkg::ACC_W-1){1'b1}}};
          end else begin
            acc_nxt = asum[rpsr_pkg::ACC_W-1:0];
          end
          mul_start_nxt = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          if (dsum < 12'sd0) begin
            duty_nxt = '0;
          end else if (dsum > 12'(duty_max_r)) begin
            duty_nxt = duty_max_r;
          end else begin
            duty_nxt = dsum[rpsr_pkg::DUTY_W-1:0];
          end
          load         = 1'b1;
          load_act     = rpsr_pkg::ACT_DUTY;
          load_restart = restart_r;
          load_speed   = speed_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // capture the state after the word into the result register
    ov_nxt        = load ? 1'b1 : (out_fire ? 1'b0 : ov_r);
    o_duty_nxt    = load ? duty_nxt     : o_duty_r;
    o_act_nxt     = load ? load_act     : o_act_r;
    o_restart_nxt = load ? load_restart : o_restart_r;
    o_speed_nxt   = load ? load_speed   : o_speed_r;
    o_ref_nxt     = load ? ref_nxt      : o_ref_r;
    o_estop_nxt   = load ? estop_nxt    : o_estop_r;
    o_stop_nxt    = load ? stop_nxt     : o_stop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= rpsr_pkg::KP_RST;
      ki_r        <= rpsr_pkg::KI_RST;
      duty_max_r  <= rpsr_pkg::DUTY_MAX_RST;
      rstep_r     <= rpsr_pkg::RAMP_STEP_RST;
      estep_r     <= rpsr_pkg::ESTOP_STEP_RST;
      band_r      <= rpsr_pkg::BAND_RST;
      release_r   <= rpsr_pkg::RELEASE_RST;
      edge_r      <= '0;
      ref_r       <= '0;
      acc_r       <= '0;
      duty_r      <= rpsr_pkg::DUTY_START_RST;
      estop_r     <= 1'b0;
      stop_r      <= 1'b1;
      state_r     <= ST_IDLE;
      mul_start_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      duty_max_r  <= duty_max_nxt;
      rstep_r     <= rstep_nxt;
      estep_r     <= estep_nxt;
      band_r      <= band_nxt;
      release_r   <= release_nxt;
      edge_r      <= edge_nxt;
      ref_r       <= ref_nxt;
      acc_r       <= acc_nxt;
      duty_r      <= duty_nxt;
      estop_r     <= estop_nxt;
      stop_r      <= stop_nxt;
      state_r     <= state_nxt;
      mul_start_r <= mul_start_nxt;
      ov_r        <= ov_nxt;
    end
    cnt_r       <= cnt_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    target_r    <= target_nxt;
    req_r       <= req_nxt;
    speed_r     <= speed_nxt;
    restart_r   <= restart_nxt;
    err_r       <= err_nxt;
    o_duty_r    <= o_duty_nxt;
    o_act_r     <= o_act_nxt;
    o_restart_r <= o_restart_nxt;
    o_speed_r   <= o_speed_nxt;
    o_ref_r     <= o_ref_nxt;
    o_estop_r   <= o_estop_nxt;
    o_stop_r    <= o_stop_nxt;
  end

  assign out_item.valid            = ov_r;
  assign out_item.duty_percent     = o_duty_r;
  assign out_item.drive_action     = o_act_r;
  assign out_item.restart_pulse    = o_restart_r;
  assign out_item.measured_rpm_q8  = o_speed_r;
  assign out_item.reference_rpm_q8 = o_ref_r;
  assign out_item.estop_active     = o_estop_r;
  assign out_item.stop_active      = o_stop_r;
endmodule

// ===== rtl/core/rpsr_checker.sv =====
// Port-level checks of the speed regulator, bound to the top level.
// Depends on rpsr_pkg for operation and action codes.
`timescale 1ns / 1ps
module rpsr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [rpsr_pkg::OP_W-1:0]           in_operation,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rpsr_pkg::ACTION_W-1:0]       out_action,
  input logic                                out_restart,
  input logic [rpsr_pkg::SPEED_W-1:0]        out_speed,
  input logic [rpsr_pkg::REF_W-1:0]          out_ref
);
  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // hall, start and stop words answer on the next cycle
  a_fast_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation != rpsr_pkg::OP_TICK |=> out_valid)
    else $error("non-tick word did not answer next cycle");

  // a word with no drive action carries no measurement
  a_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == rpsr_pkg::ACT_NONE |-> out_speed == '0 && !out_restart)
    else $error("measurement on a non-tick word");

  // a halted motor has a zero reference
  a_halt_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == rpsr_pkg::ACT_HALT |-> out_ref == '0)
    else $error("halt with nonzero reference");
endmodule

bind ramped_pi_motor_speed_regulator rpsr_checker u_rpsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .in_operation (in_item.operation),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_action   (out_item.drive_action),
  .out_restart  (out_item.restart_pulse),
  .out_speed    (out_item.measured_rpm_q8),
  .out_ref      (out_item.reference_rpm_q8)
);

// ===== sim/rpsr_checker.sv =====
// Checker of the ramped PI speed regulator: watches the input, result and register channels.
// Predicts every result word and compares it field by field. Depends on rpsr_pkg and rpsr_if.
`timescale 1ns / 1ps
module rpsr_tb_checker (
  input  logic       clk,
  input  logic       rst_n,
  rpsr_in_if         in_ch,
  rpsr_out_if        out_ch,
  rpsr_cfg_if        cfg_ch,
  output int         fail_count,
  output int         pending,
  output int         words_checked,
  output int         halts_seen,
  output int         duty_steps_seen
);
  typedef struct packed {
    logic [rpsr_pkg::DUTY_W-1:0]   duty;
    logic [rpsr_pkg::ACTION_W-1:0] action;
    logic                          restart;
    logic [rpsr_pkg::SPEED_W-1:0]  speed;
    logic [rpsr_pkg::REF_W-1:0]    refq;
    logic                          estop;
    logic                          stopf;
  } speed_word_t;

  // Register copy
  logic [rpsr_pkg::GAIN_W-1:0]    kp, ki;
  logic [rpsr_pkg::DUTY_W-1:0]    duty_start_r, duty_max_r;
  logic [rpsr_pkg::STEP_W-1:0]    ramp_step, estop_step;
  logic [rpsr_pkg::BAND_W-1:0]    band;
  logic [rpsr_pkg::RELEASE_W-1:0] release_rpm;

  // Regulator state copy
  logic [7:0] edges;
  longint     ref_q8, err_sum;
  int         duty;
  bit         estop_l, stop_l;

  speed_word_t expected_words[$];

  // Truncated PI increment, saturated to the delta limit
  function automatic int pi_increment(longint e, longint s);
    logic signed [127:0] total, mag, q;
    total = $signed({80'd0, kp}) * 128'(e) + $signed({80'd0, ki}) * 128'(s);
    mag = (total < 0) ? -total : total;
    q = mag >>> 48;
    if (q > rpsr_pkg::DELTA_LIMIT) q = rpsr_pkg::DELTA_LIMIT;
    return (total < 0) ? -int'(q) : int'(q);
  endfunction

  // Advance the state copy by one input word and form its result
  function automatic speed_word_t regulate(logic [rpsr_pkg::OP_W-1:0] op,
                                           logic [rpsr_pkg::TARGET_W-1:0] tgt, bit req);
    speed_word_t w;
    longint speed, target, bnd, num;
    int d;
    w = '0;
    speed = 0;
    target = longint'(tgt);
    bnd = longint'(band);
    case (op)
      rpsr_pkg::OP_HALL: begin
        if (edges != 8'd255) edges = edges + 8'd1;
      end
      rpsr_pkg::OP_START: begin
        edges = '0;
        stop_l = 0;
      end
      rpsr_pkg::OP_STOP: begin
        stop_l = 1;
      end
      default: begin
        num = longint'(edges) * 60 * rpsr_pkg::TICKS_PER_SECOND * 256
              + rpsr_pkg::EDGES_PER_REV / 2;
        speed = num / rpsr_pkg::EDGES_PER_REV;
        if (speed > 16777215) speed = 16777215;
        edges = '0;
        if (speed == 0 && !estop_l && !stop_l) w.restart = 1;
        if (estop_l || stop_l || speed > (target + bnd) * 256 || speed < (target - bnd) * 256)
        begin
          if (estop_l && speed != 0) ref_q8 -= longint'(estop_step);
          else if (stop_l && speed != 0) ref_q8 -= longint'(ramp_step);
          else if (speed < (target - rpsr_pkg::ACCEL_MARGIN_RPM) * 256)
            ref_q8 += longint'(ramp_step);
          else ref_q8 -= longint'(ramp_step);
          if (ref_q8 > 64'sd2147483647) ref_q8 = 64'sd2147483647;
          if (ref_q8 < -64'sd2147483648) ref_q8 = -64'sd2147483648;
        end else begin
          ref_q8 = target * 256;
        end
        if (!estop_l) estop_l = req;
        if (estop_l && speed <= longint'(release_rpm) * 256) begin
          estop_l = 0;
          stop_l = 1;
          ref_q8 = 0;
          w.action = rpsr_pkg::ACT_HALT;
        end else if (stop_l && speed <= rpsr_pkg::STOP_RELEASE_RPM * 256) begin
          ref_q8 = 0;
          w.action = rpsr_pkg::ACT_HALT;
        end else begin
          err_sum += ref_q8 - speed;
          if (err_sum > 64'sd140737488355327) err_sum = 64'sd140737488355327;
          if (err_sum < -64'sd140737488355328) err_sum = -64'sd140737488355328;
          d = duty + pi_increment(ref_q8 - speed, err_sum);
          if (d < 0) d = 0;
          else if (d > int'(duty_max_r)) d = int'(duty_max_r);
          duty = d;
          w.action = rpsr_pkg::ACT_DUTY;
        end
      end
    endcase
    w.duty = duty[rpsr_pkg::DUTY_W-1:0];
    w.speed = speed[rpsr_pkg::SPEED_W-1:0];
    w.refq = ref_q8[rpsr_pkg::REF_W-1:0];
    w.estop = estop_l;
    w.stopf = stop_l;
    return w;
  endfunction

  assign pending = expected_words.size();

  // Watch all three channels, predict and compare
  always @(posedge clk) begin
    speed_word_t got, want;
    if (!rst_n) begin
      kp <= rpsr_pkg::KP_RST; ki <= rpsr_pkg::KI_RST;
      duty_start_r <= rpsr_pkg::DUTY_START_RST; duty_max_r <= rpsr_pkg::DUTY_MAX_RST;
      ramp_step <= rpsr_pkg::RAMP_STEP_RST; estop_step <= rpsr_pkg::ESTOP_STEP_RST;
      band <= rpsr_pkg::BAND_RST; release_rpm <= rpsr_pkg::RELEASE_RST;
      edges = '0; ref_q8 = 0; err_sum = 0;
      duty = int'(rpsr_pkg::DUTY_START_RST);
      estop_l = 0; stop_l = 1;
      expected_words.delete();
      fail_count <= 0; words_checked <= 0; halts_seen <= 0; duty_steps_seen <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          rpsr_pkg::REG_KP:         kp <= cfg_ch.data;
          rpsr_pkg::REG_KI:         ki <= cfg_ch.data;
          rpsr_pkg::REG_DUTY_START: duty_start_r <= cfg_ch.data[rpsr_pkg::DUTY_W-1:0];
          rpsr_pkg::REG_DUTY_MAX:   duty_max_r <= cfg_ch.data[rpsr_pkg::DUTY_W-1:0];
          rpsr_pkg::REG_RAMP_STEP:  ramp_step <= cfg_ch.data[rpsr_pkg::STEP_W-1:0];
          rpsr_pkg::REG_ESTOP_STEP: estop_step <= cfg_ch.data[rpsr_pkg::STEP_W-1:0];
          rpsr_pkg::REG_BAND:       band <= cfg_ch.data[rpsr_pkg::BAND_W-1:0];
          rpsr_pkg::REG_RELEASE:    release_rpm <= cfg_ch.data[rpsr_pkg::RELEASE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.duty_percent, out_ch.drive_action, out_ch.restart_pulse,
                out_ch.measured_rpm_q8, out_ch.reference_rpm_q8, out_ch.estop_active,
                out_ch.stop_active};
        words_checked <= words_checked + 1;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.action == rpsr_pkg::ACT_HALT) halts_seen <= halts_seen + 1;
          if (want.action == rpsr_pkg::ACT_DUTY) duty_steps_seen <= duty_steps_seen + 1;
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Predict after the result compare so a same-edge word never pairs with itself
      if (in_ch.valid && in_ch.ready)
        expected_words.push_back(regulate(in_ch.operation, in_ch.target_rpm,
                                          in_ch.estop_request));
    end
  end
endmodule

// ===== sim/ramped_pi_motor_speed_regulator_test.sv =====
// Testbench top of the ramped PI speed regulator: stimulus, register phases and verdict.
// Depends on rpsr_pkg, rpsr_if, the regulator RTL and rpsr_checker.
`timescale 1ns / 1ps
module ramped_pi_motor_speed_regulator_test;
  logic clk;
  logic rst_n;
  int   fail_count, pending, words_checked, halts_seen, duty_steps_seen;
  int   ticks_sent, words_sent, settings_used;
  bit   calm;
  bit   hold_off_req;

  rpsr_in_if  in_ch();
  rpsr_out_if out_ch();
  rpsr_cfg_if cfg_ch();

  ramped_pi_motor_speed_regulator u_top (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch), .out_item(out_ch), .cfg_wr(cfg_ch)
  );

  rpsr_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked),
    .halts_seen(halts_seen), .duty_steps_seen(duty_steps_seen)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("ramped_pi_motor_speed_regulator verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_off_req = 0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Offer one word; valid stays high into the next word when there is no gap
  task automatic send_word(logic [rpsr_pkg::OP_W-1:0] op, logic [rpsr_pkg::TARGET_W-1:0] tgt,
                           bit req);
    if (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.target_rpm <= tgt;
    in_ch.estop_request <= req;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    words_sent++;
    if (op == rpsr_pkg::OP_TICK) ticks_sent++;
  endtask

  // Offer one register word; valid stays high into the next write
  task automatic write_reg(logic [rpsr_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpsr_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
    end
    @(posedge clk);
  endtask

  // Drain every result, let the block settle, then load a full register set
  task automatic load_regs(logic [47:0] kp, logic [47:0] ki, logic [47:0] ds, logic [47:0] dm,
                           logic [47:0] rs, logic [47:0] es, logic [47:0] bd, logic [47:0] rl);
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    write_reg(rpsr_pkg::REG_KP, kp);
    write_reg(rpsr_pkg::REG_KI, ki);
    write_reg(rpsr_pkg::REG_DUTY_START, ds);
    write_reg(rpsr_pkg::REG_DUTY_MAX, dm);
    write_reg(rpsr_pkg::REG_RAMP_STEP, rs);
    write_reg(rpsr_pkg::REG_ESTOP_STEP, es);
    write_reg(rpsr_pkg::REG_BAND, bd);
    write_reg(rpsr_pkg::REG_RELEASE, rl);
    write_reg(4'(8 + $urandom_range(7)), {$urandom, $urandom});
    cfg_ch.valid <= 0;
    settings_used++;
  endtask

  // One motor run: start, hall bursts with ticks near the measured speed, then stop
  task automatic motor_run(int nticks);
    int n, spd, tgt;
    send_word(rpsr_pkg::OP_START, 16'($urandom), 1'($urandom));
    for (int t = 0; t < nticks; t++) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(200, 270) : $urandom_range(0, 40);
      for (int k = 0; k < n; k++) send_word(rpsr_pkg::OP_HALL, 16'($urandom), 1'($urandom));
      spd = (n > 255 ? 255 : n) * 231;
      tgt = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                     : spd + $urandom_range(1200) - 600;
      if (tgt < 0) tgt = 0;
      if (tgt > 65535) tgt = 65535;
      send_word(rpsr_pkg::OP_TICK, 16'(tgt), $urandom_range(24) == 0);
    end
    send_word(rpsr_pkg::OP_STOP, 16'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 3)) send_word(rpsr_pkg::OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(int quota);
    int start_count;
    start_count = words_sent;
    while (words_sent - start_count < quota) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom), 16'($urandom), 1'($urandom));
      else
        motor_run($urandom_range(2, 8));
    end
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.operation = rpsr_pkg::OP_HALL;
    in_ch.target_rpm = '0;
    in_ch.estop_request = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    calm = 0;
    hold_off_req = 0;
    ticks_sent = 0;
    words_sent = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: defaults, field extremes, every operation, estop, saturation
    load_regs(rpsr_pkg::KP_RST, rpsr_pkg::KI_RST, rpsr_pkg::DUTY_START_RST,
              rpsr_pkg::DUTY_MAX_RST, rpsr_pkg::RAMP_STEP_RST, rpsr_pkg::ESTOP_STEP_RST,
              rpsr_pkg::BAND_RST, rpsr_pkg::RELEASE_RST);
    send_word(rpsr_pkg::OP_TICK, 16'd0, 0);
    send_word(rpsr_pkg::OP_START, 16'hFFFF, 1);
    send_word(rpsr_pkg::OP_TICK, 16'd0, 0);
    send_word(rpsr_pkg::OP_HALL, 16'hFFFF, 1);
    send_word(rpsr_pkg::OP_HALL, 16'd0, 0);
    send_word(rpsr_pkg::OP_TICK, 16'hFFFF, 0);
    repeat (10) send_word(rpsr_pkg::OP_HALL, 16'd0, 0);
    send_word(rpsr_pkg::OP_TICK, 16'd2300, 0);
    repeat (10) send_word(rpsr_pkg::OP_HALL, 16'd0, 0);
    send_word(rpsr_pkg::OP_TICK, 16'd2300, 1);
    send_word(rpsr_pkg::OP_TICK, 16'd0, 0);
    send_word(rpsr_pkg::OP_START, 16'd0, 0);
    repeat (260) send_word(rpsr_pkg::OP_HALL, 16'd0, 0);
    send_word(rpsr_pkg::OP_TICK, 16'hFFFF, 0);
    send_word(rpsr_pkg::OP_STOP, 16'd0, 0);
    send_word(rpsr_pkg::OP_TICK, 16'd100, 0);
    send_word(rpsr_pkg::OP_TICK, 16'd100, 0);

    // Defaults, with a calm stretch and the long receiver hold-off
    calm = 1;
    hold_off_req = 1;
    random_phase(180);
    calm = 0;
    random_phase(60);

    // Extremes high
    load_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd100, 48'd127, 48'hFFFF, 48'hFFFF,
              48'h3FFF, 48'hFFFF);
    random_phase(150);

    // Extremes low
    load_regs(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
    random_phase(150);

    // Random settings, every data bit exercised
    load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(120);
    load_regs(48'($urandom_range(32'h7FFF_FFFF)) << 8, 48'($urandom_range(65535)) << 4,
              48'($urandom_range(100)), 48'($urandom_range(40, 100)),
              48'($urandom_range(4000)), 48'($urandom_range(8000)),
              48'($urandom_range(1500)), 48'($urandom_range(3000)));
    random_phase(120);

    // Drain and settle
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d words (%0d ticks) over %0d register settings", words_sent,
             ticks_sent, settings_used);
    $display("checked %0d results: %0d duty steps, %0d halts, %0d mismatches", words_checked,
             duty_steps_seen, halts_seen, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("ramped_pi_motor_speed_regulator verification clean");
    else
      $display("ramped_pi_motor_speed_regulator verification failed");
    $finish;
  end
endmodule
